[hw/rtl/position_target_drive_sequencer_macros.svh]
// Assertion macros used by the checker file.
`ifndef POSITION_TARGET_DRIVE_SEQUENCER_MACROS_SVH
`define POSITION_TARGET_DRIVE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTDS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define PTDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[hw/rtl/ptds_pkg.sv]
`default_nettype none

package ptds_pkg;

   localparam int unsigned DRIVE_COUNT = 5;
   localparam int unsigned LOCK_WIDTH  = 5;

   typedef logic [2:0]  phase_type;
   typedef logic [2:0]  err_type;
   typedef logic [1:0]  kind_type;
   typedef logic [6:0]  act_type;

   // request kinds
   localparam kind_type KIND_TICK    = 2'd0;
   localparam kind_type KIND_START   = 2'd1;
   localparam kind_type KIND_ABORT   = 2'd2;
   localparam kind_type KIND_PROCESS = 2'd3;

   // phases
   localparam phase_type PH_IDLE       = 3'd0;
   localparam phase_type PH_WAIT_POS   = 3'd1;
   localparam phase_type PH_WAIT_START = 3'd2;
   localparam phase_type PH_RUNNING    = 3'd3;
   localparam phase_type PH_REACHED    = 3'd4;
   localparam phase_type PH_ERROR      = 3'd5;

   // error codes
   localparam err_type ERR_NONE    = 3'd0;
   localparam err_type ERR_DRIVE   = 3'd1;
   localparam err_type ERR_TARGET  = 3'd2;
   localparam err_type ERR_HW      = 3'd3;
   localparam err_type ERR_INVALID = 3'd4;
   localparam err_type ERR_TIMEOUT = 3'd5;
   localparam err_type ERR_WRONG   = 3'd6;
   localparam err_type ERR_STALL   = 3'd7;

   // action flag masks
   localparam act_type ACT_UPDATE  = 7'h01;
   localparam act_type ACT_START   = 7'h02;
   localparam act_type ACT_STOP    = 7'h04;
   localparam act_type ACT_STARTED = 7'h08;
   localparam act_type ACT_DONE    = 7'h10;
   localparam act_type ACT_FAILED  = 7'h20;
   localparam act_type ACT_FREE    = 7'h40;

   // register indexes
   localparam logic [2:0] CSR_FRONT_RAISES = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_TMO   = 3'd1;
   localparam logic [2:0] CSR_PROGRESS_TMO = 3'd2;
   localparam logic [2:0] CSR_MIN_TARGET   = 3'd3;
   localparam logic [2:0] CSR_MAX_TARGET   = 3'd4;
   localparam logic [2:0] CSR_HOLD_LOCK    = 3'd5;

   // register reset values
   localparam logic [15:0] SAMPLE_TMO_RESET   = 16'd250;
   localparam logic [15:0] PROGRESS_TMO_RESET = 16'd5000;

   // result field positions in rsp_tdata
   localparam int unsigned RSP_OK_BIT    = 0;
   localparam int unsigned RSP_FAIL_BIT  = 6;
   localparam int unsigned RSP_STATE_LSB = 14;
   localparam int unsigned RSP_ERR_LSB   = 17;

endpackage

`default_nettype wire

[hw/rtl/position_target_drive_sequencer.sv]
// Position target drive sequencer.
// Channels: req_* carries one item per transfer (tuser = kind: tick, start,
// abort, process; tdata = drive, target and sample fields). rsp_* returns
// exactly one result per item: action flags, direction, lock mask and the
// status after the item. csr_* writes one of six registers; it is always
// ready and should only be used while the block is idle.
// Latency: the result for an item is valid the cycle after its transfer.
// Throughput: one item per cycle while results are taken; the whole state
// update is one pass of combinational logic from the accepted item into the
// state and result registers.
// Stall: the result register holds while rsp_tready is low, and req_tready
// drops until it is taken; a new item is taken in the same cycle the held
// result leaves.
// Reset (synchronous, active high): phase idle, no error, drive 1, no known
// position, timers zero, registers at their defaults, no result pending.
`default_nettype none

module position_target_drive_sequencer
   import ptds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] drive_select, [15:8] target_request, [16] sample_present,
   // [17] sample_fault, [18] sample_ok, [26:19] sample_area,
   // [27] drive_ready, [31:28] zero
   input  wire logic [31:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] ok, [7:1] action_flags, [8] move_dir, [13:9] lock_bits,
   // [16:14] state_code, [19:17] error_code, [22:20] active_drive,
   // [30:23] target_now, [38:31] position_now, [39] position_known
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // configuration
   logic        front_raises_ff;
   logic [15:0] sample_tmo_ff;
   logic [15:0] progress_tmo_ff;
   logic [7:0]  min_target_ff;
   logic [7:0]  max_target_ff;
   logic [4:0]  hold_lock_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   err_type     fault_ff, fault_in;
   logic [2:0]  drive_ff, drive_in;
   logic [7:0]  goal_ff, goal_in;
   logic [7:0]  seen_ff, seen_in;
   logic        seen_valid_ff, seen_valid_in;
   logic        dir_ff, dir_in;
   logic [7:0]  ref_ff, ref_in;
   logic [15:0] sample_age_ff, sample_age_in;
   logic [15:0] progress_age_ff, progress_age_in;

   // result register
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // item fields
   logic [7:0]  drive_select;
   logic [7:0]  target_request;
   logic        sample_present;
   logic        sample_fault;
   logic        sample_ok;
   logic [7:0]  sample_area;
   logic        drive_ready;

   logic        req_fire;
   logic        active;
   logic        accepted;
   logic        done;
   logic        fail_hit;
   err_type     fail_code;
   logic        reach_hit;
   logic        prep_hit;
   logic        raises;
   logic        wrong;
   logic        need_up;
   logic        ok;
   act_type     act_flags;
   logic        act_dir;
   logic [4:0]  act_lock;
   logic [4:0]  drive_bit;

   assign drive_select   = req_tdata[7:0];
   assign target_request = req_tdata[15:8];
   assign sample_present = req_tdata[16];
   assign sample_fault   = req_tdata[17];
   assign sample_ok      = req_tdata[18];
   assign sample_area    = req_tdata[26:19];
   assign drive_ready    = req_tdata[27];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign active = (phase_ff == PH_WAIT_POS) || (phase_ff == PH_WAIT_START) ||
                   (phase_ff == PH_RUNNING);
   assign raises = dir_ff ? !front_raises_ff : front_raises_ff;

   // lock bit of the chosen drive, none outside the lock field
   always_comb begin
      drive_bit = '0;
      if ((drive_ff >= 3'd1) && ({29'd0, drive_ff} <= LOCK_WIDTH)) begin
         drive_bit = 5'(5'd1 << (drive_ff - 3'd1));
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      fault_in        = fault_ff;
      drive_in        = drive_ff;
      goal_in         = goal_ff;
      seen_in         = seen_ff;
      seen_valid_in   = seen_valid_ff;
      dir_in          = dir_ff;
      ref_in          = ref_ff;
      sample_age_in   = sample_age_ff;
      progress_age_in = progress_age_ff;
      ok              = 1'b0;
      accepted        = 1'b0;
      done            = 1'b0;
      fail_hit        = 1'b0;
      fail_code       = ERR_NONE;
      reach_hit       = 1'b0;
      prep_hit        = 1'b0;
      wrong           = 1'b0;
      need_up         = 1'b0;
      act_flags       = ACT_FREE;
      act_dir         = dir_ff;
      act_lock        = hold_lock_ff;

      unique case (req_tuser)
         KIND_TICK: begin
            if (active) begin
               if (sample_age_ff != 16'hFFFF) sample_age_in = sample_age_ff + 16'd1;
               if ((phase_ff == PH_RUNNING) && (progress_age_ff != 16'hFFFF)) begin
                  progress_age_in = progress_age_ff + 16'd1;
               end
            end
         end
         KIND_START: begin
            if ((drive_select < 8'd1) || ({24'd0, drive_select} > DRIVE_COUNT)) begin
               fault_in = ERR_DRIVE;
               phase_in = PH_ERROR;
            end else if ((target_request < min_target_ff) ||
                         (target_request > max_target_ff)) begin
               fault_in = ERR_TARGET;
               phase_in = PH_ERROR;
            end else begin
               drive_in        = drive_select[2:0];
               goal_in         = target_request;
               fault_in        = ERR_NONE;
               phase_in        = PH_WAIT_POS;
               ref_in          = '0;
               sample_age_in   = '0;
               progress_age_in = '0;
               ok              = 1'b1;
            end
         end
         KIND_ABORT: begin
            ok       = active;
            phase_in = PH_IDLE;
            fault_in = ERR_NONE;
         end
         KIND_PROCESS: begin
            if (sample_present) begin
               if (sample_fault) begin
                  if (active) begin
                     fail_hit  = 1'b1;
                     fail_code = ERR_HW;
                     done      = 1'b1;
                  end
               end else if (!sample_ok) begin
                  if ((phase_ff == PH_RUNNING) || (phase_ff == PH_WAIT_START)) begin
                     fail_hit  = 1'b1;
                     fail_code = ERR_INVALID;
                     done      = 1'b1;
                  end
               end else begin
                  seen_in       = sample_area;
                  seen_valid_in = 1'b1;
                  sample_age_in = '0;
                  accepted      = 1'b1;
               end
            end

            if (!done) begin
               unique case (phase_ff)
                  PH_WAIT_POS: begin
                     if (accepted) begin
                        if (sample_area == goal_ff) reach_hit = 1'b1;
                        else prep_hit = 1'b1;
                     end else if (sample_age_in >= sample_tmo_ff) begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_TIMEOUT;
                     end
                  end
                  PH_WAIT_START: begin
                     if (sample_age_in >= sample_tmo_ff) begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_TIMEOUT;
                     end else if (drive_ready) begin
                        act_flags = act_flags | ACT_START;
                        phase_in  = PH_RUNNING;
                        ok        = 1'b1;
                     end
                  end
                  PH_RUNNING: begin
                     if (accepted) begin
                        if (ref_ff != 8'd0) begin
                           wrong = raises ? (sample_area < ref_ff) : (sample_area > ref_ff);
                        end
                        if (wrong) begin
                           fail_hit  = 1'b1;
                           fail_code = ERR_WRONG;
                           done      = 1'b1;
                        end else begin
                           if (sample_area != ref_ff) begin
                              ref_in          = sample_area;
                              progress_age_in = '0;
                           end
                           if (raises ? (sample_area >= goal_ff) : (sample_area <= goal_ff)) begin
                              reach_hit = 1'b1;
                              done      = 1'b1;
                           end
                        end
                     end
                     if (!done) begin
                        if (sample_age_in >= sample_tmo_ff) begin
                           fail_hit  = 1'b1;
                           fail_code = ERR_TIMEOUT;
                        end else if (progress_age_in >= progress_tmo_ff) begin
                           fail_hit  = 1'b1;
                           fail_code = ERR_STALL;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (fail_hit) begin
               fault_in  = fail_code;
               phase_in  = PH_ERROR;
               act_flags = act_flags | ACT_STOP | ACT_UPDATE | ACT_FREE | ACT_FAILED;
               ok        = 1'b1;
            end else if (reach_hit) begin
               act_flags = act_flags | ACT_STOP | ACT_UPDATE | ACT_FREE | ACT_DONE;
               phase_in  = PH_REACHED;
               ok        = 1'b1;
            end else if (prep_hit) begin
               need_up         = goal_ff > sample_area;
               dir_in          = (need_up == front_raises_ff) ? 1'b0 : 1'b1;
               ref_in          = sample_area;
               sample_age_in   = '0;
               progress_age_in = '0;
               act_flags       = (act_flags | ACT_STOP | ACT_UPDATE | ACT_STARTED) &
                                 ~ACT_FREE;
               act_dir         = dir_in;
               act_lock        = hold_lock_ff & ~drive_bit;
               phase_in        = PH_WAIT_START;
               ok              = 1'b1;
            end
         end
      endcase

      rsp_data_in = {seen_valid_in, seen_in, goal_in, drive_in, fault_in, phase_in,
                     act_lock, act_dir, act_flags, ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_raises_ff <= 1'b1;
         sample_tmo_ff   <= SAMPLE_TMO_RESET;
         progress_tmo_ff <= PROGRESS_TMO_RESET;
         min_target_ff   <= 8'd0;
         max_target_ff   <= 8'd255;
         hold_lock_ff    <= 5'd31;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRONT_RAISES: front_raises_ff <= csr_data[0];
            CSR_SAMPLE_TMO:   sample_tmo_ff   <= csr_data;
            CSR_PROGRESS_TMO: progress_tmo_ff <= csr_data;
            CSR_MIN_TARGET:   min_target_ff   <= csr_data[7:0];
            CSR_MAX_TARGET:   max_target_ff   <= csr_data[7:0];
            CSR_HOLD_LOCK:    hold_lock_ff    <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         fault_ff        <= ERR_NONE;
         drive_ff        <= 3'd1;
         goal_ff         <= '0;
         seen_ff         <= '0;
         seen_valid_ff   <= 1'b0;
         dir_ff          <= 1'b0;
         ref_ff          <= '0;
         sample_age_ff   <= '0;
         progress_age_ff <= '0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         fault_ff        <= fault_in;
         drive_ff        <= drive_in;
         goal_ff         <= goal_in;
         seen_ff         <= seen_in;
         seen_valid_ff   <= seen_valid_in;
         dir_ff          <= dir_in;
         ref_ff          <= ref_in;
         sample_age_ff   <= sample_age_in;
         progress_age_ff <= progress_age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[hw/rtl/ptds_checker.sv]
`default_nettype none

`include "position_target_drive_sequencer_macros.svh"

module ptds_checker
   import ptds_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   logic    rsp_err_state;
   err_type rsp_err;
   logic    rsp_failed;
   logic    rsp_ok;
   logic    rsp_stall;
   logic    req_pending;

   assign rsp_err_state = rsp_tdata[RSP_STATE_LSB +: 3] == PH_ERROR;
   assign rsp_err       = rsp_tdata[RSP_ERR_LSB +: 3];
   assign rsp_failed    = rsp_tdata[RSP_FAIL_BIT];
   assign rsp_ok        = rsp_tdata[RSP_OK_BIT];
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign req_pending   = req_tvalid;

   // a stalled result holds
   `PTDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // input side opens whenever no result is waiting or the waiting one is taken
   `PTDS_ASSERT_IMPLY(a_req_open, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   // error code is set exactly in the error phase
   `PTDS_ASSERT_IMPLY(a_err_phase, clock, reset, rsp_tvalid, rsp_err_state == (rsp_err != ERR_NONE))
   // a failure report always lands in the error phase with ok set
   `PTDS_ASSERT_IMPLY(a_fail_state, clock, reset, rsp_tvalid && rsp_failed, rsp_err_state && rsp_ok)
   // an accepted item always shows a result next cycle
   `PTDS_ASSERT_NEXT(a_rsp_follows, clock, reset, req_pending && req_tready, rsp_tvalid)

endmodule

bind position_target_drive_sequencer ptds_checker u_ptds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
